FILE: hw/rtl/lrupr_pkg.sv
// shared constants and types of the lru page replacement core
`default_nettype none

package lrupr_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 5;

  // reset value of frames_in_use
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

  // apb port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index as decoded from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_FRAMES_IN_USE = '0;

  // outcome of one lookup
  typedef struct packed {
    logic hit;    // page was resident
    logic evict;  // a resident page is replaced
  } lrupr_dec_t;

  // saturating increment of the fault counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == '1) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lru_page_replacement_core.sv
// top level of the lru page replacement core
//
// one page request per input word, one result word per request
// input channel: in_valid_i / in_stall_o carry page_number_i
// output channel: out_valid_o / out_stall_i carry hit_o, frame_slot_o,
//   evicted_valid_o, evicted_page_o and fault_count_o
// a word moves at a rising edge with valid high and stall low
// path: an accepted request goes into the input register; its lookup and
//   frame update write the result register once that register is free
// throughput: one request per cycle without stalls; all frames are compared
//   in parallel and the lru victim comes from a flat rank compare, so the
//   frame state is updated in the same cycle the result is registered
// when the receiver stalls, the result register holds and the input
//   register still takes one more word; after that in_stall_o rises
// reset: all frames empty, ranks zero, fault count zero, frames_in_use 16
// configuration: apb write of frames_in_use at byte address 0, only while
//   no request is in flight; frames at or above the new count (min 1) are emptied
`default_nettype none

module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // apb configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  output logic      [APB_DW-1:0]    prdata,
  output logic                      pready,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PAGE_BITS-1:0] page_number_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      hit_o,
  output logic      [SLOT_W-1:0]    frame_slot_o,
  output logic                      evicted_valid_o,
  output logic      [PAGE_BITS-1:0] evicted_page_o,
  output logic      [COUNT_W-1:0]   fault_count_o
);

  // ranks run from zero (most recent) to FRAMES-1
  localparam int unsigned RankW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // configuration
  logic [FRAMES-1:0] active, keep;
  logic              cfg_clr;

  // input register
  logic                 in_vld_q;
  logic [PAGE_BITS-1:0] page_q;

  // result register
  logic                 out_vld_q;
  logic                 hit_q, ev_vld_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [COUNT_W-1:0]   fault_cnt_q;

  // fault counter
  logic [COUNT_W-1:0] faults_q, faults_d;

  // frame state and lookup
  logic [FRAMES-1:0][PAGE_BITS-1:0] pages;
  logic [FRAMES-1:0]                valid;
  logic [FRAMES-1:0][RankW-1:0]     ranks, rank_d;
  lrupr_dec_t                       dec;
  logic [FRAMES-1:0]                slot_oh;
  logic [SLOT_W-1:0]                slot;
  logic [PAGE_BITS-1:0]             ev_page;

  logic adv, upd;

  lrupr_cfg_regs #(
    .FRAMES (FRAMES)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .active_o (active),
    .clr_o    (cfg_clr),
    .keep_o   (keep)
  );

  // result register frees up when empty or being taken
  assign adv        = ~out_vld_q | ~out_stall_i;
  // the request in the input register is looked up and committed
  assign upd        = in_vld_q & adv;
  assign in_stall_o = in_vld_q & ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      page_q <= page_number_i;
    end
  end

  lrupr_select #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .RANK_W    (RankW)
  ) u_select (
    .page_i    (page_q),
    .active_i  (active),
    .valid_i   (valid),
    .pages_i   (pages),
    .ranks_i   (ranks),
    .dec_o     (dec),
    .slot_oh_o (slot_oh),
    .slot_o    (slot),
    .ev_page_o (ev_page),
    .rank_d_o  (rank_d)
  );

  lrupr_frame_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .RANK_W    (RankW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .dec_i     (dec),
    .slot_oh_i (slot_oh),
    .page_i    (page_q),
    .rank_d_i  (rank_d),
    .clr_i     (cfg_clr),
    .keep_i    (keep),
    .pages_o   (pages),
    .valid_o   (valid),
    .ranks_o   (ranks)
  );

  // count faults, saturating at all ones
  always_comb begin
    faults_d = faults_q;
    if (upd && !dec.hit) begin
      faults_d = sat_inc(faults_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      faults_q <= faults_d;
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      hit_q       <= dec.hit;
      slot_q      <= slot;
      ev_vld_q    <= dec.evict;
      ev_page_q   <= ev_page;
      fault_cnt_q <= faults_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_cnt_q;

  // a committed request always lands in exactly one frame
  assert property (@(posedge clk_i) disable iff (!rst_ni) upd |-> $onehot(slot_oh))
    else $error("slot select not one-hot");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(hit_q && ev_vld_q))
    else $error("hit reported with eviction");

  // the fault counter never goes back
  assert property (@(posedge clk_i) disable iff (!rst_ni) faults_q >= $past(faults_q))
    else $error("fault count decreased");

  // an eviction implies at least one fault so far
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && dec.evict) |=> faults_q != '0)
    else $error("eviction without fault");

endmodule

`default_nettype wire

FILE: hw/rtl/lrupr_cfg_regs.sv
// apb register block holding frames_in_use and the active frame mask
`default_nettype none

module lrupr_cfg_regs
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [FRAMES-1:0] active_o,
  output logic                   clr_o,
  output logic      [FRAMES-1:0] keep_o
);

  logic [CFG_W-1:0] frames_q, frames_d;
  logic             we;

  assign pready = 1'b1;
  assign we     = psel & penable & pwrite & (paddr[APB_AW-1:2] == REG_FRAMES_IN_USE);
  assign clr_o  = we;

  always_comb begin
    frames_d = frames_q;
    if (we) begin
      frames_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_IN_USE_RST;
    end else begin
      frames_q <= frames_d;
    end
  end

  // zero acts as one, values above the frame count clamp naturally
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active_o[i] = (i == 0) || (32'(i) < 32'(frames_q));
      keep_o[i]   = (i == 0) || (32'(i) < 32'(pwdata[CFG_W-1:0]));
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_FRAMES_IN_USE) begin
      prdata = APB_DW'(frames_q);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lrupr_select.sv
// parallel lookup: hit, empty and victim search plus next recency ranks
`default_nettype none

module lrupr_select
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  parameter int unsigned RANK_W    = 4
) (
  input  wire logic [PAGE_BITS-1:0]             page_i,
  input  wire logic [FRAMES-1:0]                active_i,
  input  wire logic [FRAMES-1:0]                valid_i,
  input  wire logic [FRAMES-1:0][PAGE_BITS-1:0] pages_i,
  input  wire logic [FRAMES-1:0][RANK_W-1:0]    ranks_i,
  output lrupr_dec_t                            dec_o,
  output logic      [FRAMES-1:0]                slot_oh_o,
  output logic      [SLOT_W-1:0]                slot_o,
  output logic      [PAGE_BITS-1:0]             ev_page_o,
  output logic      [FRAMES-1:0][RANK_W-1:0]    rank_d_o
);

  localparam logic [RANK_W-1:0] RankMax = RANK_W'(FRAMES - 1);
  localparam logic [RANK_W:0]   RankNew = (RANK_W + 1)'(FRAMES);

  logic [FRAMES-1:0] match, empty, hit_oh, empty_oh, victim_oh;
  logic              any_hit, any_empty;
  logic [RANK_W:0]   old_rank;
  logic [RANK_W-1:0] hit_rank;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_i[i] & active_i[i] & (pages_i[i] == page_i);
      empty[i] = active_i[i] & ~valid_i[i];
    end
  end

  // lowest set bit
  assign hit_oh    = match & (~match + FRAMES'(1));
  assign empty_oh  = empty & (~empty + FRAMES'(1));
  assign any_hit   = |match;
  assign any_empty = |empty;

  // largest rank wins, lowest index on a tie
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      victim_oh[i] = active_i[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active_i[j] && j != i) begin
          if (j < i) begin
            if (ranks_i[j] >= ranks_i[i]) victim_oh[i] = 1'b0;
          end else begin
            if (ranks_i[j] > ranks_i[i]) victim_oh[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    dec_o.hit   = any_hit;
    dec_o.evict = ~any_hit & ~any_empty;
    if (any_hit) begin
      slot_oh_o = hit_oh;
    end else if (any_empty) begin
      slot_oh_o = empty_oh;
    end else begin
      slot_oh_o = victim_oh;
    end
  end

  always_comb begin
    slot_o    = '0;
    ev_page_o = '0;
    hit_rank  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (slot_oh_o[i]) slot_o = slot_o | SLOT_W'(i);
      if (hit_oh[i]) hit_rank = hit_rank | ranks_i[i];
      if (dec_o.evict && victim_oh[i]) ev_page_o = ev_page_o | pages_i[i];
    end
  end

  assign old_rank = any_hit ? {1'b0, hit_rank} : RankNew;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_d_o[i] = ranks_i[i];
      if (slot_oh_o[i]) begin
        rank_d_o[i] = '0;
      end else if (valid_i[i] && active_i[i] && ({1'b0, ranks_i[i]} < old_rank)
                   && ranks_i[i] != RankMax) begin
        rank_d_o[i] = ranks_i[i] + RANK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lrupr_frame_store.sv
// frame pages, valid bits and recency ranks
`default_nettype none

module lrupr_frame_store
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  parameter int unsigned RANK_W    = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             upd_i,
  input  wire lrupr_dec_t                       dec_i,
  input  wire logic [FRAMES-1:0]                slot_oh_i,
  input  wire logic [PAGE_BITS-1:0]             page_i,
  input  wire logic [FRAMES-1:0][RANK_W-1:0]    rank_d_i,
  input  wire logic                             clr_i,
  input  wire logic [FRAMES-1:0]                keep_i,
  output logic      [FRAMES-1:0][PAGE_BITS-1:0] pages_o,
  output logic      [FRAMES-1:0]                valid_o,
  output logic      [FRAMES-1:0][RANK_W-1:0]    ranks_o
);

  logic [FRAMES-1:0][PAGE_BITS-1:0] pages_q;
  logic [FRAMES-1:0]                valid_q;
  logic [FRAMES-1:0][RANK_W-1:0]    ranks_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAMES; i++) begin
      if (upd_i && !dec_i.hit && slot_oh_i[i]) begin
        pages_q[i] <= page_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ranks_q <= '0;
    end else if (clr_i) begin
      // frames beyond the new count drop out
      for (int i = 0; i < FRAMES; i++) begin
        if (!keep_i[i]) begin
          valid_q[i] <= 1'b0;
          ranks_q[i] <= '0;
        end
      end
    end else if (upd_i) begin
      valid_q <= valid_q | slot_oh_i;
      ranks_q <= rank_d_i;
    end
  end

  assign pages_o = pages_q;
  assign valid_o = valid_q;
  assign ranks_o = ranks_q;

endmodule

`default_nettype wire
